### rtl/bpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bpa_pkg;

    // Bitmap geometry
    localparam int BITMAP_WORDS = 4096;
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int SUM_ROWS     = (BITMAP_WORDS + WORD_BITS - 1) / WORD_BITS;
    localparam int ROW_AW       = (SUM_ROWS > 1) ? $clog2(SUM_ROWS) : 1;
    localparam int BM_AW        = ROW_AW + BIT_W;
    localparam int BM_DEPTH     = SUM_ROWS * WORD_BITS;

    // Word field widths
    localparam int ACT_W   = 2;
    localparam int PAGE_W  = 17;
    localparam int COUNT_W = 18;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Request codes
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_TAKE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd2;

    // Index of the lowest set bit of a bitmap word (0 when the word is empty)
    function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_BITS-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

### rtl/bpa_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpa_req_if;
    logic                        valid;
    logic                        ready;
    logic [bpa_pkg::ACT_W-1:0]   action;
    logic [bpa_pkg::PAGE_W-1:0]  page_number;

    modport source (output valid, output action, output page_number, input ready);
    modport sink   (input valid, input action, input page_number, output ready);
endinterface

`default_nettype wire

### rtl/bpa_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [bpa_pkg::PAGE_W-1:0]  granted_page;
    logic [bpa_pkg::COUNT_W-1:0] free_count;

    modport source (output valid, output found, output granted_page, output free_count,
                    input ready);
    modport sink   (input valid, input found, input granted_page, input free_count,
                    output ready);
endinterface

`default_nettype wire

### rtl/bitmap_page_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// First-fit physical page allocator, one bit per page (1 = free), all pages
// taken after reset. The bitmap sits in a single-port-read synchronous RAM
// indexed by page_number>>5; a second RAM holds one "word is nonempty" bit per
// bitmap word, and a flip-flop vector marks which summary rows are nonempty.
// Of the storage only that vector is reset, so the block is usable right after
// reset with no clearing pass: a RAM row whose summary bit is clear reads as
// all zeros. Free and take requests pass through ST_IDLE (accept) and ST_UPD
// (write back after the RAM read), then respond from the output register; an
// allocate that finds a page passes through ST_IDLE, ST_COL and ST_FIN, set by
// the dependent summary read followed by the bitmap read. An allocate with
// nothing free and the unused code take the ST_UPD path. A stalled response
// holds the block in ST_UPD or ST_FIN until the output register is taken.
// One request is in flight at a time; a new request is accepted while the
// previous response still waits in the output register.
// free_count saturates at 0 and at its 18-bit maximum.

module bitmap_page_allocator (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bpa_req_if.sink    i_req,
    bpa_rsp_if.source  o_rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_UPD  = 4'b0010,
        ST_COL  = 4'b0100,
        ST_FIN  = 4'b1000
    } t_state;

    localparam int RA = bpa_pkg::ROW_AW;
    localparam int BW = bpa_pkg::BIT_W;
    localparam int WB = bpa_pkg::WORD_BITS;

    // Storage
    logic [WB-1:0]                 bitmap_mem  [bpa_pkg::BM_DEPTH];
    logic [WB-1:0]                 summary_mem [bpa_pkg::SUM_ROWS];
    logic [bpa_pkg::SUM_ROWS-1:0]  r_top;
    logic [WB-1:0]                 r_bm_q;
    logic [WB-1:0]                 r_sum_q;

    // Control and request context
    t_state                        r_state, n_state;
    logic [bpa_pkg::ACT_W-1:0]     r_act;
    logic [RA-1:0]                 r_row;
    logic [BW-1:0]                 r_col;
    logic [BW-1:0]                 r_bit;
    logic                          r_in_range;
    logic [bpa_pkg::COUNT_W-1:0]   r_free_cnt, n_free_cnt;

    // Output register
    logic                          r_out_valid;
    logic                          r_found, n_found;
    logic [bpa_pkg::PAGE_W-1:0]    r_granted, n_granted;
    logic [bpa_pkg::COUNT_W-1:0]   r_count;

    // Datapath signals
    logic                          accept;
    logic                          fin_go;
    logic                          finish;
    logic                          is_alloc;
    logic                          top_any;
    logic [RA-1:0]                 top_row;
    logic [RA-1:0]                 page_row;
    logic [BW-1:0]                 page_col;
    logic [BW-1:0]                 page_bit;
    logic                          page_ok;
    logic                          sum_re;
    logic [RA-1:0]                 sum_raddr;
    logic                          sum_we;
    logic [WB-1:0]                 sum_wdata;
    logic                          bm_re;
    logic [bpa_pkg::BM_AW-1:0]     bm_raddr;
    logic [bpa_pkg::BM_AW-1:0]     bm_waddr;
    logic                          bm_we;
    logic [WB-1:0]                 bm_wdata;
    logic [WB-1:0]                 old_sum;
    logic [WB-1:0]                 old_word;
    logic [WB-1:0]                 new_word;
    logic [WB-1:0]                 new_sum;
    logic [BW-1:0]                 sum_col;
    logic [BW-1:0]                 alloc_bit;
    logic                          upd_write;

    assign i_req.ready = (r_state == ST_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign fin_go      = !r_out_valid || o_rsp.ready;
    assign is_alloc    = (i_req.action == bpa_pkg::ACT_ALLOC);

    // Split the page number into summary row, word column, bit and in-range flag
    assign page_row = RA'({{RA{1'b0}}, i_req.page_number} >> (2 * BW));
    assign page_col = i_req.page_number[2*BW-1:BW];
    assign page_bit = i_req.page_number[BW-1:0];
    assign page_ok  = (32'(i_req.page_number) >> BW) < 32'(bpa_pkg::BITMAP_WORDS);

    // Find the lowest nonempty summary row
    always_comb begin
        top_row = '0;
        top_any = 1'b0;
        for (int i = bpa_pkg::SUM_ROWS - 1; i >= 0; i--) begin
            if (r_top[i]) begin
                top_row = RA'(i);
                top_any = 1'b1;
            end
        end
    end

    // Mask stale RAM contents of rows and words that are known empty
    assign old_sum  = r_top[r_row] ? r_sum_q : '0;
    assign old_word = old_sum[r_col] ? r_bm_q : '0;
    assign sum_col  = bpa_pkg::lowest_bit(r_sum_q);
    assign alloc_bit = bpa_pkg::lowest_bit(r_bm_q);

    // Build the modified bitmap word and summary row
    always_comb begin
        new_word = old_word;
        if (r_state == ST_FIN) begin
            new_word = r_bm_q;
            new_word[alloc_bit] = 1'b0;
        end else if (r_act == bpa_pkg::ACT_FREE) begin
            new_word[r_bit] = 1'b1;
        end else begin
            new_word[r_bit] = 1'b0;
        end
        new_sum = old_sum;
        new_sum[r_col] = |new_word;
    end

    assign upd_write = (r_state == ST_UPD) && fin_go && r_in_range &&
                       ((r_act == bpa_pkg::ACT_FREE) || (r_act == bpa_pkg::ACT_TAKE));
    assign finish    = fin_go && ((r_state == ST_UPD) || (r_state == ST_FIN));

    // RAM port controls
    assign sum_re    = accept;
    assign sum_raddr = is_alloc ? top_row : page_row;
    assign sum_we    = upd_write || ((r_state == ST_FIN) && fin_go);
    assign sum_wdata = new_sum;

    always_comb begin
        bm_re    = 1'b0;
        bm_raddr = {page_row, page_col};
        if (r_state == ST_COL) begin
            bm_re    = 1'b1;
            bm_raddr = {r_row, sum_col};
        end else if (accept && !is_alloc) begin
            bm_re = 1'b1;
        end
    end
    assign bm_we    = sum_we;
    assign bm_waddr = {r_row, r_col};
    assign bm_wdata = new_word;

    // Next counter value and response payload
    always_comb begin
        n_free_cnt = r_free_cnt;
        n_found    = 1'b0;
        n_granted  = '0;
        if (r_state == ST_FIN) begin
            n_found   = 1'b1;
            n_granted = bpa_pkg::PAGE_W'({r_row, r_col, alloc_bit});
            if (r_free_cnt != '0) begin
                n_free_cnt = r_free_cnt - 1'b1;
            end
        end else if (upd_write) begin
            if (r_act == bpa_pkg::ACT_FREE) begin
                if (r_free_cnt != bpa_pkg::COUNT_MAX) begin
                    n_free_cnt = r_free_cnt + 1'b1;
                end
            end else if (r_free_cnt != '0) begin
                n_free_cnt = r_free_cnt - 1'b1;
            end
        end
    end

    // Advance the request sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (is_alloc && top_any) ? ST_COL : ST_UPD;
                end
            end
            ST_COL:  n_state = ST_FIN;
            ST_UPD,
            ST_FIN: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Bitmap RAM
    always_ff @(posedge i_clk) begin
        if (bm_we) begin
            bitmap_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            r_bm_q <= bitmap_mem[bm_raddr];
        end
    end

    // Summary RAM
    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            summary_mem[r_row] <= sum_wdata;
        end
        if (sum_re) begin
            r_sum_q <= summary_mem[sum_raddr];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_top       <= '0;
            r_free_cnt  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_free_cnt <= (finish) ? n_free_cnt : r_free_cnt;
            if (sum_we) begin
                r_top[r_row] <= |new_sum;
            end
            if (finish) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold request context and response word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_act      <= i_req.action;
            r_row      <= sum_raddr;
            r_col      <= page_col;
            r_bit      <= page_bit;
            r_in_range <= page_ok;
        end else if (r_state == ST_COL) begin
            r_col <= sum_col;
        end
        if (finish) begin
            r_found   <= n_found;
            r_granted <= n_granted;
            r_count   <= n_free_cnt;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_found;
    assign o_rsp.granted_page = r_granted;
    assign o_rsp.free_count   = r_count;

endmodule

`default_nettype wire

### test/bpa_grant_checker.sv
`timescale 1ns / 1ps

// Watches the request and response channels of the page allocator, keeps a
// shadow copy of the free-page bitmap and counter, and compares every
// response word against the grant predicted for the oldest open request.
module bpa_grant_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bpa_req_if   req_mon,
    bpa_rsp_if   rsp_mon,
    output int   o_mismatches,
    output int   o_pending
);

    typedef struct packed {
        logic                        found;
        logic [bpa_pkg::PAGE_W-1:0]  page;
        logic [bpa_pkg::COUNT_W-1:0] count;
    } t_grant;

    // Shadow of the allocator state: one bit per page, 1 = free
    logic [bpa_pkg::WORD_BITS-1:0] page_map [bpa_pkg::BITMAP_WORDS];
    logic [bpa_pkg::COUNT_W-1:0]   shadow_count;

    t_grant expected_grants [$];
    int     mismatch_count = 0;

    // Apply one request to the shadow state and return the grant it yields
    function automatic t_grant predict_grant(input logic [bpa_pkg::ACT_W-1:0]  act,
                                             input logic [bpa_pkg::PAGE_W-1:0] page);
        t_grant      g;
        int unsigned w;
        int unsigned b;
        g = '0;
        w = int'(page) >> bpa_pkg::BIT_W;
        b = int'(page[bpa_pkg::BIT_W-1:0]);
        case (act)
            bpa_pkg::ACT_FREE: begin
                if (w < bpa_pkg::BITMAP_WORDS) begin
                    page_map[w][b] = 1'b1;
                    if (shadow_count != bpa_pkg::COUNT_MAX) shadow_count = shadow_count + 1'b1;
                end
            end
            bpa_pkg::ACT_TAKE: begin
                if (w < bpa_pkg::BITMAP_WORDS) begin
                    page_map[w][b] = 1'b0;
                    if (shadow_count != '0) shadow_count = shadow_count - 1'b1;
                end
            end
            bpa_pkg::ACT_ALLOC: begin
                // first fit: lowest word with a free page, then its lowest bit
                for (w = 0; w < bpa_pkg::BITMAP_WORDS && !g.found; w++) begin
                    if (page_map[w] != '0) begin
                        b = 0;
                        while (!page_map[w][b]) b++;
                        page_map[w][b] = 1'b0;
                        if (shadow_count != '0) shadow_count = shadow_count - 1'b1;
                        g.found = 1'b1;
                        g.page  = bpa_pkg::PAGE_W'(w * bpa_pkg::WORD_BITS + b);
                    end
                end
            end
            default: ;
        endcase
        g.count = shadow_count;
        return g;
    endfunction

    task automatic flag_grant_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Check the response word first, then queue the grant for a new request
    always @(posedge i_clk) begin : track_grants
        t_grant want;
        t_grant got;
        if (!i_rst_n) begin
            for (int i = 0; i < bpa_pkg::BITMAP_WORDS; i++) page_map[i] = '0;
            shadow_count = '0;
            expected_grants.delete();
        end else begin
            if (rsp_mon.valid && rsp_mon.ready) begin
                got.found = rsp_mon.found;
                got.page  = rsp_mon.granted_page;
                got.count = rsp_mon.free_count;
                if (expected_grants.size() == 0) begin
                    flag_grant_error($sformatf(
                        "[%0t] unexpected response: found %0b page %0d count %0d",
                        $realtime, got.found, got.page, got.count));
                end else begin
                    want = expected_grants.pop_front();
                    if (got.found !== want.found || got.page !== want.page ||
                        got.count !== want.count) begin
                        flag_grant_error($sformatf(
                            {"[%0t] grant mismatch: found exp %0b got %0b, ",
                             "page exp %0d got %0d, count exp %0d got %0d"},
                            $realtime, want.found, got.found, want.page, got.page,
                            want.count, got.count));
                    end
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                expected_grants.push_back(predict_grant(req_mon.action, req_mon.page_number));
            end
        end
        o_pending    <= expected_grants.size();
        o_mismatches <= mismatch_count;
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the page allocator. Prediction and checking live
// in bpa_grant_checker.
module tb_top;

    // Request code with no operation behind it
    localparam logic [bpa_pkg::ACT_W-1:0] ACT_NONE = 2'd3;
    localparam int PAGE_TOP = (1 << bpa_pkg::PAGE_W) - 1;

    logic i_clk;
    logic i_rst_n;

    bpa_req_if req_ch ();
    bpa_rsp_if rsp_ch ();

    int grants_waiting;
    int grant_errors;

    // Sender and receiver pacing
    int tx_gap_max = 0;
    int burst_left = 0;
    int rx_stall_rate;
    int rx_stall_max;
    int rx_stall_left = 0;

    int n_free = 0;
    int n_take = 0;
    int n_alloc = 0;
    int n_unused = 0;

    bitmap_page_allocator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    bpa_grant_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_ch),
        .rsp_mon      (rsp_ch),
        .o_mismatches (grant_errors),
        .o_pending    (grants_waiting)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop for a hung handshake
    initial begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Receiver: stall for random stretches at the configured rate
    initial rsp_ch.ready = 1'b0;
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            rsp_ch.ready  <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (rx_stall_rate != 0 && $urandom_range(0, 99) < rx_stall_rate) begin
            rsp_ch.ready  <= 1'b0;
            rx_stall_left <= $urandom_range(0, rx_stall_max);
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // Hold one request word until it is taken
    task automatic send_request(input logic [bpa_pkg::ACT_W-1:0] act,
                                input logic [bpa_pkg::PAGE_W-1:0] page);
        req_ch.valid       <= 1'b1;
        req_ch.action      <= act;
        req_ch.page_number <= page;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        case (act)
            bpa_pkg::ACT_FREE:  n_free++;
            bpa_pkg::ACT_TAKE:  n_take++;
            bpa_pkg::ACT_ALLOC: n_alloc++;
            default:            n_unused++;
        endcase
    endtask

    // Send, then drop valid for a random gap at the end of each burst
    task automatic send_paced(input logic [bpa_pkg::ACT_W-1:0] act,
                              input logic [bpa_pkg::PAGE_W-1:0] page);
        int gap;
        send_request(act, page);
        if (tx_gap_max != 0) begin
            if (burst_left == 0) begin
                gap = $urandom_range(1, tx_gap_max);
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Pages cluster low so allocates find them, with some far out and at the top
    function automatic logic [bpa_pkg::PAGE_W-1:0] pick_page();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return bpa_pkg::PAGE_W'($urandom_range(0, 127));
        if (r < 80) return bpa_pkg::PAGE_W'($urandom_range(0, PAGE_TOP));
        return bpa_pkg::PAGE_W'(PAGE_TOP - $urandom_range(0, 63));
    endfunction

    task automatic send_random_request();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 38)      send_paced(bpa_pkg::ACT_FREE, pick_page());
        else if (r < 55) send_paced(bpa_pkg::ACT_TAKE, pick_page());
        else if (r < 92) send_paced(bpa_pkg::ACT_ALLOC,
                                    bpa_pkg::PAGE_W'($urandom_range(0, PAGE_TOP)));
        else             send_paced(ACT_NONE, bpa_pkg::PAGE_W'($urandom_range(0, PAGE_TOP)));
    endtask

    // Hold the sender until every open request has its response
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (grants_waiting != 0) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.action      <= bpa_pkg::ACT_FREE;
        req_ch.page_number <= '0;
        rx_stall_rate      <= 25;
        rx_stall_max       <= 4;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty bitmap, counter floor, edge pages, double free
        send_paced(bpa_pkg::ACT_ALLOC, bpa_pkg::PAGE_W'(PAGE_TOP));
        send_paced(bpa_pkg::ACT_TAKE, '0);
        send_paced(ACT_NONE, bpa_pkg::PAGE_W'(PAGE_TOP));
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(PAGE_TOP));
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(bpa_pkg::ACT_FREE, '0);
        send_paced(bpa_pkg::ACT_FREE, '0);
        send_paced(bpa_pkg::ACT_ALLOC, bpa_pkg::PAGE_W'(PAGE_TOP));
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(bpa_pkg::ACT_TAKE, bpa_pkg::PAGE_W'(5));
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(31));
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(32));
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(17'h0FFFF));
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(17'h10000));
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(bpa_pkg::ACT_TAKE, bpa_pkg::PAGE_W'(17'h0FFFF));
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(ACT_NONE, bpa_pkg::PAGE_W'(17'h15555));
        send_paced(ACT_NONE, bpa_pkg::PAGE_W'(17'h0AAAA));
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(1));
        send_paced(bpa_pkg::ACT_TAKE, bpa_pkg::PAGE_W'(1));
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        drain_results();

        // Random traffic in phases of different pacing
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_gap_max = 4;
                    rx_stall_rate <= 25;
                    rx_stall_max  <= 5;
                end
                1: begin
                    tx_gap_max = 0;
                    rx_stall_rate <= 0;
                    rx_stall_max  <= 0;
                end
                2: begin
                    tx_gap_max = 2;
                    rx_stall_rate <= 60;
                    rx_stall_max  <= 12;
                end
                default: begin
                    tx_gap_max = 8;
                    rx_stall_rate <= 10;
                    rx_stall_max  <= 3;
                end
            endcase
            repeat (325) send_random_request();
            drain_results();
        end

        // Close with a short full-rate run around the top and bottom pages
        tx_gap_max = 0;
        rx_stall_rate <= 0;
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(bpa_pkg::ACT_FREE, bpa_pkg::PAGE_W'(PAGE_TOP));
        send_paced(bpa_pkg::ACT_FREE, '0);
        send_paced(bpa_pkg::ACT_TAKE, bpa_pkg::PAGE_W'(7));
        send_paced(bpa_pkg::ACT_ALLOC, '0);
        send_paced(ACT_NONE, '0);

        drain_results();
        repeat (16) @(posedge i_clk);

        $display("Drove %0d requests: %0d free, %0d take, %0d allocate, %0d unused code.",
                 n_free + n_take + n_alloc + n_unused, n_free, n_take, n_alloc, n_unused);
        $display("Counter held at zero, repeated frees and takes, edge pages; pacing from "
                 , "full rate to heavy stalls.");
        if (grant_errors == 0 && grants_waiting == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
